### rtl/dscc_pkg.sv
package dscc_pkg;

  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
  localparam logic [15:0] ADLER_MOD = 16'd65521;

  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_CHECK = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic        use_fnv;
    logic [63:0] expected_sum;
  } in_item_t;

  typedef struct packed {
    logic [63:0] fnv_digest;
    logic [63:0] fast_digest;
    logic        match;
  } out_item_t;

  typedef struct packed {
    logic fold;
    logic clear;
  } sum_ctl_t;

  typedef struct packed {
    logic [63:0] fnv;
    logic [63:0] fast;
  } digest_t;

endpackage

### rtl/dscc_sums.sv
module dscc_sums
  import dscc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  sum_ctl_t   ctl,
  input  logic [7:0] data_byte,
  output digest_t    digest
);

  logic [63:0] fnv_sum, fnv_sum_next;
  logic [31:0] crc_reg, crc_reg_next;
  logic [15:0] adler_low, adler_low_next;
  logic [15:0] adler_high, adler_high_next;

  logic [63:0] fnv_x;
  logic [31:0] crc_c;
  logic [16:0] lo_sum;
  logic [16:0] hi_sum;

  // FNV prime is 2^40 + 0x1B3, so the multiply is a sum of shifts
  always_comb begin
    fnv_x = fnv_sum ^ {56'd0, data_byte};
    fnv_sum_next = (fnv_x << 40) + (fnv_x << 8) + (fnv_x << 7) + (fnv_x << 5)
                 + (fnv_x << 4) + (fnv_x << 1) + fnv_x;
  end

  always_comb begin
    crc_c = crc_reg ^ {24'd0, data_byte};
    for (int i = 0; i < 8; i++) begin
      if (crc_c[0]) begin
        crc_c = (crc_c >> 1) ^ CRC_POLY;
      end else begin
        crc_c = crc_c >> 1;
      end
    end
    crc_reg_next = crc_c;
  end

  // both sums stay below the modulus, so one conditional subtract suffices
  always_comb begin
    lo_sum = {1'b0, adler_low} + {9'd0, data_byte};
    if (lo_sum >= {1'b0, ADLER_MOD}) begin
      lo_sum = lo_sum - {1'b0, ADLER_MOD};
    end
    adler_low_next = lo_sum[15:0];
    hi_sum = {1'b0, adler_high} + {1'b0, adler_low_next};
    if (hi_sum >= {1'b0, ADLER_MOD}) begin
      hi_sum = hi_sum - {1'b0, ADLER_MOD};
    end
    adler_high_next = hi_sum[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      fnv_sum    <= FNV_BASIS;
      crc_reg    <= CRC_INIT;
      adler_low  <= 16'd1;
      adler_high <= 16'd0;
    end else if (ctl.fold) begin
      fnv_sum    <= fnv_sum_next;
      crc_reg    <= crc_reg_next;
      adler_low  <= adler_low_next;
      adler_high <= adler_high_next;
    end
  end

  assign digest.fnv  = fnv_sum;
  assign digest.fast = {~crc_reg, adler_high, adler_low};

  a_adler_range: assert property (@(posedge clk) disable iff (rst)
    adler_low < ADLER_MOD && adler_high < ADLER_MOD)
    else $error("adler sums out of range");

  a_clear_restores: assert property (@(posedge clk) disable iff (rst)
    ctl.clear |=> fnv_sum == FNV_BASIS && crc_reg == CRC_INIT
                  && adler_low == 16'd1 && adler_high == 16'd0)
    else $error("sums not restored after check");

  a_ctl_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(ctl.fold && ctl.clear))
    else $error("fold and clear together");

endmodule

### rtl/dual_stream_checksum_checker.sv
// Channel | Signals                    | Payload
// in      | in_valid, in_stall         | in_data  (kind, data_byte, use_fnv, expected_sum)
// out     | out_valid, out_stall       | out_data (fnv_digest, fast_digest, match)
//
// One item per cycle is taken while in_stall is low. A check result passes
// through the input register and then the result register.
// The per-byte FNV/CRC/Adler recurrence is computed combinationally in dscc_sums.
// rst (synchronous) empties both registers and sets the sums to their start values.
// While a result waits on out_stall, data bytes still flow; a second check
// waits in the input register and in_stall rises only then.
module dual_stream_checksum_checker
  import dscc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  in_item_t  in_q;
  logic      in_q_valid;
  logic      process;
  logic      is_check;
  logic      accept;
  sum_ctl_t  ctl;
  digest_t   digest;
  logic      hit;

  assign is_check = in_q.kind == KIND_CHECK;
  assign process  = in_q_valid && (!is_check || !out_valid || !out_stall);
  assign in_stall = in_q_valid && !process;
  assign accept   = in_valid && !in_stall;

  assign ctl.fold  = process && !is_check;
  assign ctl.clear = process && is_check;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (accept) begin
      in_q_valid <= 1'b1;
    end else if (process) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q <= in_data;
    end
  end

  dscc_sums u_sums (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .data_byte (in_q.data_byte),
    .digest    (digest)
  );

  assign hit = in_q.use_fnv ? (digest.fnv == in_q.expected_sum)
                            : (digest.fast == in_q.expected_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.clear) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      out_data.fnv_digest  <= digest.fnv;
      out_data.fast_digest <= digest.fast;
      out_data.match       <= hit;
    end
  end

  a_check_gives_result: assert property (@(posedge clk) disable iff (rst)
    ctl.clear |=> out_valid)
    else $error("check transfer produced no result");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_q_valid && is_check && out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("pending result lost");

endmodule

### test/dual_stream_checksum_checker_tb.sv
`timescale 1ns / 1ps

module dual_stream_checksum_checker_tb;
  import dscc_pkg::*;

  localparam logic [63:0] FNV_PRIME    = 64'h0000_0100_0000_01B3;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned RANDOM_ITEMS = 900;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // running sums as the block should hold them
  logic [63:0] fnv_run;
  logic [31:0] crc_run;
  logic [15:0] adler_a;
  logic [15:0] adler_b;
  out_item_t   digest_q[$];
  out_item_t   head;

  bit          steady      = 1'b0;
  int unsigned stall_left  = 0;
  int unsigned cycles      = 0;
  int unsigned errors      = 0;
  int unsigned transfers   = 0;
  int unsigned checks_done = 0;
  int unsigned hits        = 0;

  dual_stream_checksum_checker i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  function void clear_sums();
    fnv_run = FNV_BASIS;
    crc_run = CRC_INIT;
    adler_a = 16'd1;
    adler_b = 16'd0;
  endfunction

  function void fold_byte(logic [7:0] b);
    logic [63:0] x;
    logic [31:0] c;
    logic [16:0] s;
    int          i;
    x = fnv_run ^ {56'd0, b};
    fnv_run = x * FNV_PRIME;
    c = crc_run ^ {24'd0, b};
    for (i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    crc_run = c;
    s = adler_a + b;
    if (s >= ADLER_MOD) s = s - ADLER_MOD;
    adler_a = s[15:0];
    s = adler_b + adler_a;
    if (s >= ADLER_MOD) s = s - ADLER_MOD;
    adler_b = s[15:0];
  endfunction

  function out_item_t predict_check(logic use_fnv, logic [63:0] trailer);
    out_item_t r;
    r.fnv_digest  = fnv_run;
    r.fast_digest = {crc_run ^ 32'hFFFF_FFFF, adler_b, adler_a};
    r.match       = use_fnv ? (fnv_run == trailer) : (r.fast_digest == trailer);
    return r;
  endfunction

  function logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(in_item_t it);
    int unsigned gap;
    bit          taken;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    transfers++;
    if (it.kind == KIND_DATA) begin
      fold_byte(it.data_byte);
    end else begin
      digest_q = {digest_q, predict_check(it.use_fnv, it.expected_sum)};
      clear_sums();
    end
  endtask

  task automatic send_data(logic [7:0] b);
    in_item_t it;
    it.kind         = KIND_DATA;
    it.data_byte    = b;
    it.use_fnv      = 1'($urandom_range(0, 1));
    it.expected_sum = rand64();
    send_item(it);
  endtask

  task automatic send_check(logic use_fnv, logic [63:0] trailer);
    in_item_t it;
    it.kind         = KIND_CHECK;
    it.data_byte    = 8'($urandom_range(0, 255));
    it.use_fnv      = use_fnv;
    it.expected_sum = trailer;
    send_item(it);
  endtask

  // trailer is mostly correct, sometimes corrupted or for the other sum
  task automatic close_stream();
    out_item_t   now;
    logic        sel;
    logic [63:0] t;
    int unsigned r;
    sel = 1'($urandom_range(0, 1));
    now = predict_check(sel, '0);
    t   = sel ? now.fnv_digest : now.fast_digest;
    r   = $urandom_range(0, 9);
    if (r == 6 || r == 7) t = t ^ (64'd1 << $urandom_range(0, 63));
    else if (r == 8) t = sel ? now.fast_digest : now.fnv_digest;
    else if (r == 9) t = rand64();
    send_check(sel, t);
  endtask

  task automatic send_stream(int unsigned len);
    repeat (len) send_data(8'($urandom_range(0, 255)));
    close_stream();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_stream();
    send_check(1'b1, FNV_BASIS);
    send_check(1'b0, {32'h0, 32'h1});
    send_check(1'b1, {32'h0, 32'h1});
    send_check(1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_field_extremes();
    in_item_t  it;
    out_item_t p;
    send_data(8'h00);
    send_data(8'hFF);
    send_check(1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    it.kind         = KIND_DATA;
    it.data_byte    = 8'hFF;
    it.use_fnv      = 1'b1;
    it.expected_sum = 64'hFFFF_FFFF_FFFF_FFFF;
    send_item(it);
    it.data_byte    = 8'h00;
    it.use_fnv      = 1'b0;
    it.expected_sum = '0;
    send_item(it);
    send_data(8'h80);
    send_data(8'h01);
    p = predict_check(1'b0, '0);
    send_check(1'b0, p.fast_digest);
    send_data(8'h7F);
    p = predict_check(1'b1, '0);
    send_check(1'b1, p.fnv_digest);
    it.kind         = KIND_CHECK;
    it.data_byte    = 8'hFF;
    it.use_fnv      = 1'b0;
    it.expected_sum = {32'h0, 32'h1};
    send_item(it);
  endtask

  // enough 0xFF bytes to push both Adler halves past the modulus
  task automatic test_long_streams();
    out_item_t p;
    repeat (300) send_data(8'hFF);
    p = predict_check(1'b0, '0);
    send_check(1'b0, p.fast_digest);
    send_stream(300);
  endtask

  task automatic test_back_to_back();
    int unsigned n;
    steady = 1'b1;
    n = transfers;
    while (transfers - n < 150) send_stream($urandom_range(0, 6));
    steady = 1'b0;
    repeat (12) close_stream();
  endtask

  task automatic test_drain_pause();
    repeat (3) send_stream($urandom_range(1, 10));
    drain();
    repeat (3) send_stream($urandom_range(0, 10));
    drain();
  endtask

  task automatic test_random_streams();
    int unsigned n;
    int unsigned r;
    n = transfers;
    while (transfers - n < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 10) send_stream(0);
      else if (r < 85) send_stream($urandom_range(1, 16));
      else if (r < 97) send_stream($urandom_range(17, 80));
      else send_stream($urandom_range(100, 300));
      if ($urandom_range(0, 49) == 0) steady = ~steady;
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst || steady) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < 65) begin
      out_stall <= 1'b0;
    end else begin
      stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      out_stall <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        $error("result transfer with no check pending");
        errors++;
      end else begin
        head = digest_q.pop_front();
        checks_done++;
        if (head.match) hits++;
        if (out_data.fnv_digest !== head.fnv_digest) begin
          $error("fnv_digest: expected %h, got %h", head.fnv_digest, out_data.fnv_digest);
          errors++;
        end
        if (out_data.fast_digest !== head.fast_digest) begin
          $error("fast_digest: expected %h, got %h", head.fast_digest, out_data.fast_digest);
          errors++;
        end
        if (out_data.match !== head.match) begin
          $error("match: expected %b, got %b", head.match, out_data.match);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    clear_sums();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_stream();
    test_field_extremes();
    test_long_streams();
    test_back_to_back();
    test_drain_pause();
    test_random_streams();
    drain();
    repeat (10) @(posedge clk);
    $display("covered %0d transfers, %0d checks compared (%0d trailer matches)",
             transfers, checks_done, hits);
    $display("empty, long, back-to-back and random byte streams under random stalls");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
